// ===== src/drcs_pkg.sv =====
// Shared constants, codes and types for the dual-range current sensor.
package drcs_pkg;

  // Default parameter values
  localparam int ADC_BITS_DEF         = 12;
  localparam int FILTER_FRAC_BITS_DEF = 16;

  // Arithmetic constants
  localparam int MV_FULL_Q4 = 3300 * 16;   // full scale in mV, Q.4
  localparam int MA_SCALE   = 16000;       // Q.4 mV and Q8.8 gain to mA
  localparam int GAIN_MIN   = 3;           // 0.01 mV/A in Q8.8
  localparam int CUR_LIMIT  = 1000000;     // +-1000 A in mA
  localparam int EMA_DEN    = 10;          // 0.1 filter weight
  localparam int ACC_W      = 48;          // filter accumulator
  localparam int CH_W       = 32;          // channel currents
  localparam int CUR_W      = 21;          // clamped current
  localparam int DEN_W      = 16;          // divisor width
  localparam int MVQ_W      = 16;          // scaled reading, Q.4 mV
  localparam int MAG_W      = 17;          // corrected magnitude, Q.4 mV
  localparam int MA_NUM_W   = 31;          // channel divide numerator

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_OFFSET_LOW  = 3'd1,
    REG_OFFSET_HIGH = 3'd2,
    REG_DEADBAND    = 3'd3,
    REG_GAIN_LOW    = 3'd4,
    REG_GAIN_HIGH   = 3'd5,
    REG_SWITCH      = 3'd6
  } cfg_reg_t;

  // Sensor modes; codes from MODE_IDLE_LO up to MODE_IDLE_HI are idle
  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_DUAL    = 3'd1;
  localparam logic [2:0] MODE_BUS     = 3'd2;
  localparam logic [2:0] MODE_SINGLE  = 3'd3;
  localparam logic [2:0] MODE_IDLE_LO = 3'd4;
  localparam logic [2:0] MODE_IDLE_HI = 3'd7;

  // Range codes
  localparam logic [1:0] RANGE_NONE = 2'd0;
  localparam logic [1:0] RANGE_LOW  = 2'd1;
  localparam logic [1:0] RANGE_HIGH = 2'd2;

  // Result beat layout
  localparam int OUT_CUR_LSB    = 0;
  localparam int OUT_AVG_LSB    = 21;
  localparam int OUT_RANGE_LSB  = 53;
  localparam int OUT_LO_LSB     = 55;
  localparam int OUT_HI_LSB     = 87;
  localparam int OUT_BADLO_BIT  = 119;
  localparam int OUT_BADHI_BIT  = 120;
  localparam int OUT_W          = 128;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MV_LD,
    ST_MV_RUN,
    ST_ADJ,
    ST_MA_LD,
    ST_MA_RUN,
    ST_SEL,
    ST_SUM,
    ST_EMA_LD,
    ST_EMA_RUN,
    ST_FIN,
    ST_OUT
  } drcs_state_t;

endpackage

// ===== src/dual_range_current_sense.sv =====
// Dual-range shunt current sensor: two ADC channels or a bus value, clamp and EMA filter.
//
// One beat in, one beat out. Each channel reading is scaled to Q.4 mV, offset
// corrected, deadbanded and divided by its mV/A gain; the selected current
// feeds a 0.1 exponential filter outside the idle modes. All divisions run on
// one bit-serial divider (DIV_W wide, 53 bits at default parameters) that
// yields one quotient bit per cycle, so the divider sets the time per beat.
// An invalid gain skips that channel's divide. A new beat is taken only while
// the sequencer is idle; the result waits in an output register, so the next
// beat is accepted while it is still pending. Configuration is taken every
// cycle and must only change while no beat is in flight.
module dual_range_current_sense #(
  parameter int ADC_BITS         = drcs_pkg::ADC_BITS_DEF,
  parameter int FILTER_FRAC_BITS = drcs_pkg::FILTER_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input beat
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata from bit 0 up: adc_low, adc_high, bus_current_ma, zero padding
  input  logic [((2*ADC_BITS+21+7)/8)*8-1:0] in_tdata,
  // Result beat
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata from bit 0 up: current_ma, avg_current_ma, range_used, low_range_ma,
  // high_range_ma, gain_low_bad, gain_high_bad, zero padding
  output logic [drcs_pkg::OUT_W-1:0]       out_tdata,
  // Configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [drcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int FS      = (1 << ADC_BITS) - 1;
  localparam int MV_N    = ADC_BITS + 16;
  localparam int SUM_W   = ((drcs_pkg::ACC_W + 4 > 32 + FILTER_FRAC_BITS) ?
                            drcs_pkg::ACC_W + 4 : 32 + FILTER_FRAC_BITS) + 1;
  localparam int DIV_W   = SUM_W;
  localparam int CNT_W   = $clog2(DIV_W + 1);
  localparam int ACC_W   = drcs_pkg::ACC_W;
  localparam int CH_W    = drcs_pkg::CH_W;
  localparam int CUR_W   = drcs_pkg::CUR_W;
  localparam int DEN_W   = drcs_pkg::DEN_W;
  localparam int MA_N    = drcs_pkg::MA_NUM_W;
  localparam int MAG_W   = drcs_pkg::MAG_W;
  localparam int MVQ_W   = drcs_pkg::MVQ_W;

  // Configuration registers
  logic [2:0]  mode_r;
  logic [11:0] off_lo_r;
  logic [11:0] off_hi_r;
  logic [11:0] db_r;
  logic [15:0] gain_lo_r;
  logic [15:0] gain_hi_r;
  logic [19:0] switch_r;

  // Sequencer
  drcs_pkg::drcs_state_t state_r, state_nxt;

  // Captured beat and working registers
  logic [ADC_BITS-1:0]     adc_lo_r;
  logic [ADC_BITS-1:0]     adc_hi_r;
  logic signed [20:0]      bus_r;
  logic                    chan_r;      // 0 low channel, 1 high channel
  logic [MVQ_W-1:0]        mvq_r;
  logic [MAG_W-1:0]        mag_r;
  logic                    neg_r;
  logic signed [CH_W-1:0]  lo_ma_r;
  logic signed [CH_W-1:0]  hi_ma_r;
  logic                    bad_lo_r;
  logic                    bad_hi_r;
  logic signed [CH_W-1:0]  raw_r;
  logic [1:0]              range_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    out_valid_r;
  logic [drcs_pkg::OUT_W-1:0] out_data_r;

  // Divider hookup
  logic             div_start;
  logic [CNT_W-1:0] div_len;
  logic [DIV_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [DIV_W-1:0] quo;

  logic in_accept;
  logic out_load;

  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= drcs_pkg::MODE_NONE;
      off_lo_r  <= '0;
      off_hi_r  <= '0;
      db_r      <= '0;
      gain_lo_r <= '0;
      gain_hi_r <= '0;
      switch_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (drcs_pkg::cfg_reg_t'(cfg_index))
        drcs_pkg::REG_MODE:        mode_r    <= cfg_data[2:0];
        drcs_pkg::REG_OFFSET_LOW:  off_lo_r  <= cfg_data[11:0];
        drcs_pkg::REG_OFFSET_HIGH: off_hi_r  <= cfg_data[11:0];
        drcs_pkg::REG_DEADBAND:    db_r      <= cfg_data[11:0];
        drcs_pkg::REG_GAIN_LOW:    gain_lo_r <= cfg_data[15:0];
        drcs_pkg::REG_GAIN_HIGH:   gain_hi_r <= cfg_data[15:0];
        drcs_pkg::REG_SWITCH:      switch_r  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Channel operand selection; single analog mode uses low input, high gain
  logic [ADC_BITS-1:0] adc_sel;
  logic [11:0]         off_sel;
  logic [15:0]         gain_sel;
  logic                gain_bad;
  logic                use_dual;
  logic                is_idle_mode;
  logic                chan_more;

  assign use_dual     = mode_r == drcs_pkg::MODE_DUAL;
  assign is_idle_mode = mode_r inside {[drcs_pkg::MODE_IDLE_LO:drcs_pkg::MODE_IDLE_HI]};
  assign adc_sel      = chan_r ? adc_hi_r : adc_lo_r;
  assign off_sel      = chan_r ? off_hi_r : off_lo_r;
  assign gain_sel     = (use_dual && !chan_r) ? gain_lo_r : gain_hi_r;
  assign gain_bad     = gain_sel < 16'(drcs_pkg::GAIN_MIN);
  assign chan_more    = use_dual && !chan_r;

  // Divide numerators
  logic [MV_N-1:0]  mv_num;
  logic [MA_N-1:0]  ma_num;
  logic [SUM_W-1:0] ema_mag;

  assign mv_num = MV_N'(adc_sel) * MV_N'(drcs_pkg::MV_FULL_Q4) + MV_N'(FS / 2);
  assign ma_num = MA_N'(mag_r) * MA_N'(drcs_pkg::MA_SCALE) + MA_N'(gain_sel >> 1);
  // |sum| + 5 for round half away from zero; ~x + 6 == -x + 5
  assign ema_mag = sum_r[SUM_W-1] ? ($unsigned(~sum_r) + SUM_W'(6))
                                  : ($unsigned(sum_r) + SUM_W'(5));

  drcs_sdiv #(
    .NUM_W(DIV_W),
    .DEN_W(DEN_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .len  (div_len),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (quo)
  );

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= drcs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and divider launch
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    div_len   = CNT_W'(DIV_W);
    div_num   = '0;
    div_den   = DEN_W'(drcs_pkg::EMA_DEN);
    out_load  = 1'b0;
    case (state_r)
      drcs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (use_dual || mode_r == drcs_pkg::MODE_SINGLE) begin
            state_nxt = drcs_pkg::ST_MV_LD;
          end else begin
            state_nxt = drcs_pkg::ST_SEL;
          end
        end
      end
      drcs_pkg::ST_MV_LD: begin
        div_start = 1'b1;
        div_len   = CNT_W'(MV_N);
        div_num   = DIV_W'(mv_num) << (DIV_W - MV_N);
        div_den   = DEN_W'(FS);
        state_nxt = drcs_pkg::ST_MV_RUN;
      end
      drcs_pkg::ST_MV_RUN: begin
        if (div_done) state_nxt = drcs_pkg::ST_ADJ;
      end
      drcs_pkg::ST_ADJ: begin
        state_nxt = drcs_pkg::ST_MA_LD;
      end
      drcs_pkg::ST_MA_LD: begin
        div_len = CNT_W'(MA_N);
        div_num = DIV_W'(ma_num) << (DIV_W - MA_N);
        div_den = gain_sel;
        if (gain_bad) begin
          state_nxt = chan_more ? drcs_pkg::ST_MV_LD : drcs_pkg::ST_SEL;
        end else begin
          div_start = 1'b1;
          state_nxt = drcs_pkg::ST_MA_RUN;
        end
      end
      drcs_pkg::ST_MA_RUN: begin
        if (div_done) begin
          state_nxt = chan_more ? drcs_pkg::ST_MV_LD : drcs_pkg::ST_SEL;
        end
      end
      drcs_pkg::ST_SEL: begin
        state_nxt = is_idle_mode ? drcs_pkg::ST_OUT : drcs_pkg::ST_SUM;
      end
      drcs_pkg::ST_SUM: begin
        state_nxt = drcs_pkg::ST_EMA_LD;
      end
      drcs_pkg::ST_EMA_LD: begin
        div_start = 1'b1;
        div_num   = ema_mag;
        state_nxt = drcs_pkg::ST_EMA_RUN;
      end
      drcs_pkg::ST_EMA_RUN: begin
        if (div_done) state_nxt = drcs_pkg::ST_FIN;
      end
      drcs_pkg::ST_FIN: begin
        state_nxt = drcs_pkg::ST_OUT;
      end
      drcs_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = drcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = drcs_pkg::ST_IDLE;
      end
    endcase
  end

  // Offset and deadband on the scaled reading
  logic signed [MAG_W:0] mv_corr;
  logic [MAG_W-1:0]      mv_abs;
  logic                  in_dead;

  assign mv_corr = $signed({2'b00, mvq_r}) - $signed({2'b00, off_sel, 4'b0000});
  assign mv_abs  = mv_corr[MAG_W] ? MAG_W'(-mv_corr) : MAG_W'(mv_corr);
  assign in_dead = mv_abs < {1'b0, db_r, 4'b0000};

  // Signed channel current; quotient stays below 2^29 so no saturation is hit
  logic [CH_W-1:0]        ma_q;
  logic signed [CH_W-1:0] ma_val;

  assign ma_q   = quo[CH_W-1:0];
  assign ma_val = neg_r ? $signed(-ma_q) : $signed(ma_q);

  // Range switch compare
  logic [CH_W-1:0] lo_abs;
  logic            use_low;

  assign lo_abs  = lo_ma_r[CH_W-1] ? -$unsigned(lo_ma_r) : $unsigned(lo_ma_r);
  assign use_low = lo_abs < CH_W'(switch_r);

  // Filter numerator: 9 * acc + raw scaled to the filter fraction
  logic signed [SUM_W-1:0] acc_ext;
  logic signed [SUM_W-1:0] raw_ext;
  logic signed [SUM_W-1:0] sum_nxt;

  assign acc_ext = SUM_W'(acc_r);
  assign raw_ext = SUM_W'(raw_r);
  assign sum_nxt = (acc_ext <<< 3) + acc_ext + (raw_ext <<< FILTER_FRAC_BITS);

  // Filter result, saturated to the accumulator range
  logic                    q_big;
  logic signed [ACC_W-1:0] acc_nxt;

  assign q_big = |quo[DIV_W-1:ACC_W-1];

  always_comb begin
    if (!sum_r[SUM_W-1]) begin
      acc_nxt = q_big ? {1'b0, {(ACC_W-1){1'b1}}} : $signed(quo[ACC_W-1:0]);
    end else begin
      acc_nxt = q_big ? {1'b1, {(ACC_W-1){1'b0}}} : $signed(-quo[ACC_W-1:0]);
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      adc_lo_r <= in_tdata[ADC_BITS-1:0];
      adc_hi_r <= in_tdata[2*ADC_BITS-1:ADC_BITS];
      bus_r    <= $signed(in_tdata[2*ADC_BITS+20:2*ADC_BITS]);
      chan_r   <= 1'b0;
      lo_ma_r  <= '0;
      hi_ma_r  <= '0;
      bad_lo_r <= 1'b0;
      bad_hi_r <= 1'b0;
    end
    case (state_r)
      drcs_pkg::ST_MV_RUN: begin
        if (div_done) mvq_r <= quo[MVQ_W-1:0];
      end
      drcs_pkg::ST_ADJ: begin
        mag_r <= in_dead ? '0 : mv_abs;
        neg_r <= mv_corr[MAG_W];
      end
      drcs_pkg::ST_MA_LD: begin
        if (gain_bad) begin
          if (chan_r) hi_ma_r <= '0;
          else        lo_ma_r <= '0;
          if (chan_r || !use_dual) bad_hi_r <= 1'b1;
          else                     bad_lo_r <= 1'b1;
          if (chan_more) chan_r <= 1'b1;
        end
      end
      drcs_pkg::ST_MA_RUN: begin
        if (div_done) begin
          if (chan_r) hi_ma_r <= ma_val;
          else        lo_ma_r <= ma_val;
          if (chan_more) chan_r <= 1'b1;
        end
      end
      drcs_pkg::ST_SEL: begin
        case (mode_r)
          drcs_pkg::MODE_DUAL: begin
            raw_r   <= use_low ? lo_ma_r : hi_ma_r;
            range_r <= use_low ? drcs_pkg::RANGE_LOW : drcs_pkg::RANGE_HIGH;
          end
          drcs_pkg::MODE_BUS: begin
            raw_r   <= CH_W'(bus_r);
            range_r <= drcs_pkg::RANGE_NONE;
          end
          drcs_pkg::MODE_SINGLE: begin
            raw_r   <= lo_ma_r;
            range_r <= drcs_pkg::RANGE_LOW;
          end
          default: begin
            raw_r   <= '0;
            range_r <= drcs_pkg::RANGE_NONE;
          end
        endcase
      end
      drcs_pkg::ST_SUM: begin
        sum_r <= sum_nxt;
      end
      default: ;
    endcase
  end

  // Filter accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (state_r == drcs_pkg::ST_FIN) begin
      acc_r <= acc_nxt;
    end
  end

  // Clamped current and integer part of the filter
  logic [CUR_W-1:0]        cur_val;
  logic signed [ACC_W-1:0] acc_sh;
  logic                    avg_pos_ovf;
  logic                    avg_neg_ovf;
  logic [CH_W-1:0]         avg_val;

  always_comb begin
    if (raw_r > CH_W'(drcs_pkg::CUR_LIMIT)) begin
      cur_val = CUR_W'(drcs_pkg::CUR_LIMIT);
    end else if (raw_r < CH_W'(-drcs_pkg::CUR_LIMIT)) begin
      cur_val = CUR_W'(-drcs_pkg::CUR_LIMIT);
    end else begin
      cur_val = raw_r[CUR_W-1:0];
    end
  end

  assign acc_sh      = acc_r >>> FILTER_FRAC_BITS;
  assign avg_pos_ovf = !acc_sh[ACC_W-1] && (|acc_sh[ACC_W-2:CH_W-1]);
  assign avg_neg_ovf = acc_sh[ACC_W-1] && !(&acc_sh[ACC_W-2:CH_W-1]);
  assign avg_val     = avg_pos_ovf ? {1'b0, {(CH_W-1){1'b1}}} :
                       avg_neg_ovf ? {1'b1, {(CH_W-1){1'b0}}} : acc_sh[CH_W-1:0];

  // Result beat packing
  logic [drcs_pkg::OUT_W-1:0] out_data_nxt;

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[drcs_pkg::OUT_CUR_LSB   +: CUR_W] = cur_val;
    out_data_nxt[drcs_pkg::OUT_AVG_LSB   +: CH_W]  = avg_val;
    out_data_nxt[drcs_pkg::OUT_RANGE_LSB +: 2]     = range_r;
    out_data_nxt[drcs_pkg::OUT_LO_LSB    +: CH_W]  = lo_ma_r;
    out_data_nxt[drcs_pkg::OUT_HI_LSB    +: CH_W]  = hi_ma_r;
    out_data_nxt[drcs_pkg::OUT_BADLO_BIT]          = bad_lo_r;
    out_data_nxt[drcs_pkg::OUT_BADHI_BIT]          = bad_hi_r;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/drcs_sdiv.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module drcs_sdiv #(
  parameter int NUM_W = 53,
  parameter int DEN_W = drcs_pkg::DEN_W,
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] len,    // quotient bits to produce, at least one
  input  logic [NUM_W-1:0] num,    // numerator, left-aligned to len bits
  input  logic [DEN_W-1:0] den,
  output logic             done,   // one-cycle pulse, quo valid until next start
  output logic [NUM_W-1:0] quo
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;

  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // Trial subtract of the next partial remainder
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= len;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Numerator shifts out the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], fits};
      if (fits) begin
        rem_r <= DEN_W'(rem_sh - {1'b0, den_r});
      end else begin
        rem_r <= rem_sh[DEN_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// ===== src/drcs_chk.sv =====
// Port-level checker for the dual-range current sensor, bound to the top level.
module drcs_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [drcs_pkg::OUT_W-1:0]  out_tdata
);

  logic [1:0]                   range_f;
  logic signed [drcs_pkg::CUR_W-1:0] cur_f;
  logic [drcs_pkg::CH_W-1:0]    lo_f;
  logic [drcs_pkg::CH_W-1:0]    hi_f;

  assign range_f = out_tdata[drcs_pkg::OUT_RANGE_LSB +: 2];
  assign cur_f   = $signed(out_tdata[drcs_pkg::OUT_CUR_LSB +: drcs_pkg::CUR_W]);
  assign lo_f    = out_tdata[drcs_pkg::OUT_LO_LSB +: drcs_pkg::CH_W];
  assign hi_f    = out_tdata[drcs_pkg::OUT_HI_LSB +: drcs_pkg::CH_W];

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // No range: no channel currents and no gain flags
  a_no_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && range_f == drcs_pkg::RANGE_NONE |->
      lo_f == '0 && hi_f == '0 &&
      !out_tdata[drcs_pkg::OUT_BADLO_BIT] && !out_tdata[drcs_pkg::OUT_BADHI_BIT])
    else $error("channel data present with no range");

  // A bad low gain forces the low channel to zero
  a_bad_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[drcs_pkg::OUT_BADLO_BIT] |-> lo_f == '0)
    else $error("low channel nonzero with bad gain");

  // Reported current stays within the clamp and range code is known
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cur_f <= 21'sd1000000 && cur_f >= -21'sd1000000 &&
      range_f != 2'd3)
    else $error("current beyond clamp or bad range code");

endmodule

bind dual_range_current_sense drcs_chk u_drcs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
